[sv/timer_count_extend_to_ns_macros.svh]
// Assertion shorthands used by the checker file.
`ifndef TIMER_COUNT_EXTEND_TO_NS_MACROS_SVH
`define TIMER_COUNT_EXTEND_TO_NS_MACROS_SVH

// Consequence must hold in the cycle after the antecedent, outside reset.
`define TCX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after a reset cycle.
`define TCX_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[sv/tcx_pkg.sv]
`default_nettype none

package tcx_pkg;

  localparam int unsigned CNT_W      = 64;
  localparam int unsigned LOW_W      = 32;
  localparam int unsigned FREQ_W     = 30;
  localparam int unsigned ANCHOR_W   = 32;
  localparam int unsigned UNIT_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [FREQ_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [UNIT_W-1:0] UNIT_1000  = 10'd1000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDE_MODE = 2'd0,
    REG_TICK_FREQ = 2'd1,
    REG_BASELINE  = 2'd2,
    REG_ANCHOR    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_PRIME   = 1'b0,
    ACT_CONVERT = 1'b1
  } action_t;

  typedef struct packed {
    logic                wide_mode;
    logic [FREQ_W-1:0]   tick_freq;
    logic [CNT_W-1:0]    baseline;
    logic [ANCHOR_W-1:0] anchor;
  } cfg_regs_t;

  typedef struct packed {
    logic [CNT_W-1:0] ext;
  } queue_entry_t;

endpackage

`default_nettype wire

[sv/tcx_sample_if.sv]
`default_nettype none

interface tcx_sample_if;
  import tcx_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [CNT_W-1:0] counter_sample;

  modport source (output valid, action, counter_sample, input ready);
  modport sink (input valid, action, counter_sample, output ready);
endinterface

`default_nettype wire

[sv/tcx_result_if.sv]
`default_nettype none

interface tcx_result_if;
  import tcx_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] extended_count;
  logic [CNT_W-1:0] elapsed_ns;
  logic [CNT_W-1:0] wall_micros;

  modport source (output valid, extended_count, elapsed_ns, wall_micros, input ready);
  modport sink (input valid, extended_count, elapsed_ns, wall_micros, output ready);
endinterface

`default_nettype wire

[sv/tcx_cfg_if.sv]
`default_nettype none

interface tcx_cfg_if;
  import tcx_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/timer_count_extend_to_ns.sv]
// Counter timestamp unit: widens raw main-counter readings and turns them
// into nanoseconds since a baseline and wall-clock microseconds.
// Channels: sample (action, counter_sample) in, result (extended_count,
// elapsed_ns, wall_micros) out, cfg (index, data) for the four registers;
// every channel moves a word on a clock edge where valid and ready are high.
// A prime word updates the low-word latch and wrap count on acceptance and
// produces nothing. A convert word is extended on acceptance and queued.
// The back end takes a queued word only when idle and steps it through
// baseline subtract, multiply, sum, the radix-4 long divider (47 steps
// for ticks*1e9/f), a four-step reciprocal divide of ns by 1000 and the
// wall-clock sum into the result register. The queue holds two words, so
// the sample side keeps accepting while the divider works and while a
// result waits.
// A stalled receiver holds the result register; the back end then waits and
// the queue fills, after which sample.ready drops.
// Reset (rst, synchronous) clears the registers, latch, wrap count and queue
// and drops result.valid. cfg.ready stays high; write registers only while
// the block is idle.
`default_nettype none

module timer_count_extend_to_ns #(
  parameter int unsigned DEPTH = tcx_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  tcx_sample_if.sink   sample,
  tcx_result_if.source result,
  tcx_cfg_if.sink      cfg
);
  import tcx_pkg::*;

  cfg_regs_t    cfg_regs;
  logic         push_valid;
  queue_entry_t push_entry;
  logic         push_ready;
  logic         pop_valid;
  queue_entry_t pop_entry;
  logic         pop_ready;

  // Register file: accept every write at once; an unknown index is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_WIDE_MODE: cfg_regs.wide_mode <= cfg.data[0];
        REG_TICK_FREQ: cfg_regs.tick_freq <= cfg.data[FREQ_W-1:0];
        REG_BASELINE:  cfg_regs.baseline  <= cfg.data[CNT_W-1:0];
        REG_ANCHOR:    cfg_regs.anchor    <= cfg.data[ANCHOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take words, apply primes, extend convert samples.
  tcx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg_regs   (cfg_regs),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Queue: decouple the front from the long-running back end.
  tcx_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // Back: subtract baseline, scale, divide, hold the result word.
  tcx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .q_valid  (pop_valid),
    .q_entry  (pop_entry),
    .q_ready  (pop_ready),
    .result   (result)
  );

endmodule

`default_nettype wire

[sv/tcx_front.sv]
`default_nettype none

module tcx_front (
  input  logic                  clk,
  input  logic                  rst,
  tcx_sample_if.sink            sample,
  input  tcx_pkg::cfg_regs_t    cfg_regs,
  output logic                  push_valid,
  output tcx_pkg::queue_entry_t push_entry,
  input  logic                  push_ready
);
  import tcx_pkg::*;

  logic [LOW_W-1:0] latched_low;
  logic [LOW_W-1:0] latched_low_next;
  logic [LOW_W-1:0] wrap_count;
  logic [LOW_W-1:0] wrap_count_next;
  logic [LOW_W-1:0] low;
  logic             accept;

  assign sample.ready = push_ready;
  assign accept       = sample.valid && sample.ready;
  assign low          = sample.counter_sample[LOW_W-1:0];

  always_comb begin
    latched_low_next = latched_low;
    wrap_count_next  = wrap_count;
    push_valid       = 1'b0;
    push_entry.ext   = sample.counter_sample;
    if (accept) begin
      case (action_t'(sample.action))
        ACT_PRIME: begin
          latched_low_next = cfg_regs.wide_mode ? '0 : low;
          wrap_count_next  = '0;
        end
        ACT_CONVERT: begin
          push_valid = 1'b1;
          if (!cfg_regs.wide_mode) begin
            // the low word going backwards means it wrapped
            wrap_count_next  = (low < latched_low) ? wrap_count + LOW_W'(1) : wrap_count;
            latched_low_next = low;
            push_entry.ext   = {wrap_count_next, low};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_low <= '0;
      wrap_count  <= '0;
    end else begin
      latched_low <= latched_low_next;
      wrap_count  <= wrap_count_next;
    end
  end

endmodule

`default_nettype wire

[sv/tcx_queue.sv]
`default_nettype none

module tcx_queue #(
  parameter int unsigned DEPTH = tcx_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  tcx_pkg::queue_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output tcx_pkg::queue_entry_t pop_entry,
  input  logic                  pop_ready
);
  import tcx_pkg::*;

  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  queue_entry_t      mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/tcx_back.sv]
`default_nettype none

module tcx_back (
  input  logic                  clk,
  input  logic                  rst,
  input  tcx_pkg::cfg_regs_t    cfg_regs,
  input  logic                  q_valid,
  input  tcx_pkg::queue_entry_t q_entry,
  output logic                  q_ready,
  tcx_result_if.source          result
);
  import tcx_pkg::*;

  localparam int unsigned DVD_W      = CNT_W + FREQ_W;
  localparam int unsigned REM_W      = FREQ_W + 1;
  localparam int unsigned PROD_W     = LOW_W + FREQ_W;
  localparam int unsigned AK_W       = ANCHOR_W + UNIT_W;
  localparam int unsigned NS_STEPS   = DVD_W / 2;
  localparam int unsigned US_CHUNK_W = 16;
  localparam int unsigned US_STEPS   = CNT_W / US_CHUNK_W;
  localparam int unsigned US_V_W     = UNIT_W + US_CHUNK_W;
  localparam int unsigned RECIP_W    = 27;
  localparam int unsigned RECIP_SH   = 36;
  localparam int unsigned US_PROD_W  = US_V_W + RECIP_W;
  localparam int unsigned STEP_W     = $clog2(NS_STEPS);

  // ceil(2^36 / 1000)
  localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SUB    = 8'b0000_0010,
    S_MUL_LO = 8'b0000_0100,
    S_MUL_HI = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_DIV_NS = 8'b0010_0000,
    S_DIV_US = 8'b0100_0000,
    S_WALL   = 8'b1000_0000
  } back_state_t;

  back_state_t       state;
  logic [CNT_W-1:0]  ext_r;
  logic [CNT_W-1:0]  ticks;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;
  logic [AK_W-1:0]   anchor_k;
  logic [CNT_W-1:0]  ns_r;
  logic [DVD_W-1:0]  dvd;
  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] div_d;
  logic [STEP_W-1:0] step_cnt;
  logic              res_valid;
  logic [CNT_W-1:0]  res_ext;
  logic [CNT_W-1:0]  res_ns;
  logic [CNT_W-1:0]  res_us;

  logic [REM_W-1:0]  r1_sh;
  logic [REM_W-1:0]  r2_sh;
  logic              ge1;
  logic              ge2;
  logic [FREQ_W-1:0] r1;
  logic [FREQ_W-1:0] rem_step;
  logic [DVD_W-1:0]  dvd_step;
  logic [CNT_W-1:0]  ns_from_div;
  logic              freq_zero;
  logic              result_free;

  logic [CNT_W-1:0]      ns_sh;
  logic [CNT_W-1:0]      us_q;
  logic [UNIT_W-1:0]     us_rem;
  logic [US_V_W-1:0]     us_v;
  logic [US_PROD_W-1:0]  us_prod;
  logic [US_CHUNK_W-1:0] us_digit;
  logic [UNIT_W-1:0]     us_rem_step;

  // two restoring steps per cycle
  always_comb begin
    r1_sh    = {rem, dvd[DVD_W-1]};
    ge1      = (r1_sh >= {1'b0, div_d});
    r1       = ge1 ? FREQ_W'(r1_sh - {1'b0, div_d}) : r1_sh[FREQ_W-1:0];
    r2_sh    = {r1, dvd[DVD_W-2]};
    ge2      = (r2_sh >= {1'b0, div_d});
    rem_step = ge2 ? FREQ_W'(r2_sh - {1'b0, div_d}) : r2_sh[FREQ_W-1:0];
    dvd_step = {dvd[DVD_W-3:0], ge1, ge2};
  end

  // ns / 1000 sixteen bits at a time; the partial dividend stays below
  // 1000 * 2^16, where the reciprocal product floors exactly
  assign us_v        = {us_rem, ns_sh[CNT_W-1 -: US_CHUNK_W]};
  assign us_prod     = US_PROD_W'(us_v) * US_PROD_W'(RECIP_1000);
  assign us_digit    = us_prod[RECIP_SH +: US_CHUNK_W];
  assign us_rem_step = UNIT_W'(us_v - US_V_W'(us_digit) * US_V_W'(UNIT_1000));

  assign freq_zero   = (cfg_regs.tick_freq == '0);
  assign ns_from_div = freq_zero ? '0 : dvd_step[CNT_W-1:0];
  assign result_free = !res_valid || result.ready;
  assign q_ready     = (state == S_IDLE);

  assign result.valid          = res_valid;
  assign result.extended_count = res_ext;
  assign result.elapsed_ns     = res_ns;
  assign result.wall_micros    = res_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:   if (q_valid) begin
          state <= S_SUB;
        end
        S_SUB:    state <= S_MUL_LO;
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_SUM;
        S_SUM:    state <= S_DIV_NS;
        S_DIV_NS: if (step_cnt == '0) begin
          state <= S_DIV_US;
        end
        S_DIV_US: if (step_cnt == '0) begin
          state <= S_WALL;
        end
        S_WALL:   if (result_free) begin
          state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
      if (state == S_WALL && result_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_valid) begin
        ext_r <= q_entry.ext;
      end
      S_SUB: ticks <= ext_r - cfg_regs.baseline;
      S_MUL_LO: begin
        prod_lo  <= PROD_W'(ticks[LOW_W-1:0]) * PROD_W'(NS_PER_SEC);
        anchor_k <= AK_W'(cfg_regs.anchor) * AK_W'(UNIT_1000);
      end
      S_MUL_HI: prod_hi <= PROD_W'(ticks[CNT_W-1:LOW_W]) * PROD_W'(NS_PER_SEC);
      S_SUM: begin
        // ticks * 1e9 in full; its quotient by f equals the split formula
        dvd      <= {prod_hi, {LOW_W{1'b0}}} + DVD_W'(prod_lo);
        rem      <= '0;
        div_d    <= cfg_regs.tick_freq;
        step_cnt <= STEP_W'(NS_STEPS - 1);
      end
      S_DIV_NS: begin
        if (step_cnt == '0) begin
          ns_r     <= ns_from_div;
          ns_sh    <= ns_from_div;
          us_rem   <= '0;
          step_cnt <= STEP_W'(US_STEPS - 1);
        end else begin
          dvd      <= dvd_step;
          rem      <= rem_step;
          step_cnt <= step_cnt - STEP_W'(1);
        end
      end
      S_DIV_US: begin
        ns_sh  <= {ns_sh[CNT_W-US_CHUNK_W-1:0], {US_CHUNK_W{1'b0}}};
        us_q   <= {us_q[CNT_W-US_CHUNK_W-1:0], us_digit};
        us_rem <= us_rem_step;
        if (step_cnt != '0) begin
          step_cnt <= step_cnt - STEP_W'(1);
        end
      end
      S_WALL: if (result_free) begin
        res_ext <= ext_r;
        res_ns  <= ns_r;
        res_us  <= CNT_W'(anchor_k) + us_q;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/tcx_checker.sv]
`default_nettype none
`include "timer_count_extend_to_ns_macros.svh"

module tcx_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [tcx_pkg::CNT_W-1:0] out_ext,
  input logic [tcx_pkg::CNT_W-1:0] out_ns,
  input logic [tcx_pkg::CNT_W-1:0] out_us
);

  `TCX_ASSERT_RESET(a_reset_drops_result, !out_valid, "result valid after reset")
  `TCX_ASSERT_RESET(a_reset_opens_input, in_ready, "input not ready after reset")
  `TCX_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_ext) && $stable(out_ns) && $stable(out_us), "stalled result changed")
  `TCX_ASSERT_NEXT(a_no_result_burst, out_valid && out_ready && $past(out_valid && out_ready), !(out_valid && out_ready), "three results in a row")

endmodule

bind timer_count_extend_to_ns tcx_checker u_tcx_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_ext   (result.extended_count),
  .out_ns    (result.elapsed_ns),
  .out_us    (result.wall_micros)
);

`default_nettype wire
